// ===== rtl/kff_pkg.sv =====
// Shared constants, types and control structs of the KMP failure-table builder.
`default_nettype none

package kff_pkg;

    // Longest pattern that the stores can hold.
    localparam int MAX_LEN = 256;

    // Store index width, and a position counter width that can also hold MAX_LEN.
    localparam int LEN_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int POS_W = $clog2(MAX_LEN + 1);

    // Widths of the word fields.
    localparam int CH_W      = 8;
    localparam int BORDER_OW = 9;
    localparam int POS_OW    = 8;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    // Internal border values hold -1 up to MAX_LEN-2 and are never narrower than the output field.
    localparam int BRD_W  = (LEN_W + 1 > BORDER_OW) ? (LEN_W + 1) : BORDER_OW;
    // Position widened so that the output field can always be part-selected from it.
    localparam int POSX_W = (LEN_W > POS_OW) ? LEN_W : POS_OW;

    typedef logic signed [BRD_W-1:0] t_border;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // a word is accepted this cycle
        logic walk;   // take one fallback step and read the stores again
        logic done;   // the walk has ended: record the border and give the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_walk;  // the waiting character needs a fallback walk
        logic hit;        // stored character after the current border matches
        logic j_neg;      // the candidate border is empty
        logic out_free;   // the output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/kff_ctrl.sv =====
// Controller state machine of the KMP failure-table builder.
`default_nettype none

module kff_ctrl
    import kff_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = i_sts.out_free;
                if (i_s_tvalid && i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.need_walk) begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (i_sts.hit || i_sts.j_neg) begin
                    // The walk has ended; wait for room in the output register.
                    if (i_sts.out_free) begin
                        o_cmd.done = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kff_datapath.sv =====
// Datapath of the KMP failure-table builder: stores, walk registers and output register.
`default_nettype none

module kff_datapath
    import kff_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [CH_W-1:0]     i_ch,
    input  wire logic                i_last,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic                     o_m_tuser,
    output logic                     o_m_tlast
);

    // Pattern and failure stores.
    logic [CH_W-1:0] r_pat  [MAX_LEN];
    t_border         r_fail [MAX_LEN];

    // Walk registers.
    logic [CH_W-1:0]  r_ch;
    logic             r_last;
    logic [LEN_W-1:0] r_pos;
    t_border          r_j;
    logic [CH_W-1:0]  r_pat_q;
    t_border          r_fail_q;

    // Pattern state.
    logic [POS_W-1:0] r_next_pos;
    t_border          r_cur_border;
    logic             r_overflowed;

    // Output register.
    logic                 r_out_valid;
    logic [BORDER_OW-1:0] r_out_border;
    logic [POS_OW-1:0]    r_out_pos;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic             ovf_now;
    logic             pos_zero;
    logic [LEN_W-1:0] pos_now;
    t_border          j_fb;
    t_border          j_inc;
    t_border          done_border;
    t_border          rd_j;
    t_border          rd_j_inc;
    logic             rd_en;
    logic [LEN_W-1:0] pat_raddr;
    logic [LEN_W-1:0] fail_raddr;
    logic             pat_we;
    logic             fail_we;
    logic [LEN_W-1:0] fail_waddr;
    t_border          fail_wdata;
    logic             res_load;
    t_border          res_border;
    logic [LEN_W-1:0] res_pos;
    logic [POSX_W-1:0] res_pos_x;
    logic             res_ovf;
    logic             res_last;

    // Classification of the waiting character and walk status.
    always_comb begin
        ovf_now  = r_overflowed || (r_next_pos >= POS_W'(MAX_LEN));
        pos_zero = (r_next_pos == '0);
        pos_now  = r_next_pos[LEN_W-1:0];

        o_sts.need_walk = !ovf_now && !pos_zero;
        o_sts.hit       = (r_pat_q == r_ch);
        o_sts.j_neg     = r_j[BRD_W-1];
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

    // Fallback step, the border found, and the store read addresses.
    always_comb begin
        // The fallback must strictly shrink; anything else ends the walk.
        j_fb        = (r_fail_q < r_j) ? r_fail_q : '1;
        j_inc       = r_j + t_border'(1);
        done_border = o_sts.hit ? j_inc : '1;

        rd_j       = i_cmd.load ? r_cur_border : j_fb;
        rd_j_inc   = rd_j + t_border'(1);
        rd_en      = (i_cmd.load && o_sts.need_walk) || i_cmd.walk;
        pat_raddr  = rd_j_inc[LEN_W-1:0];
        fail_raddr = rd_j[BRD_W-1] ? '0 : rd_j[LEN_W-1:0];

        pat_we     = i_cmd.load && !ovf_now;
        fail_we    = (i_cmd.load && pos_zero && !ovf_now) || i_cmd.done;
        fail_waddr = i_cmd.done ? r_pos : '0;
        fail_wdata = i_cmd.done ? done_border : '1;
    end

    // Result selection: immediate on acceptance when no walk is needed, or at the end of a walk.
    always_comb begin
        res_load   = (i_cmd.load && !o_sts.need_walk) || i_cmd.done;
        res_border = i_cmd.done ? done_border : '1;
        res_pos    = i_cmd.done ? r_pos : '0;
        res_pos_x  = POSX_W'(res_pos);
        res_ovf    = i_cmd.load && ovf_now;
        res_last   = i_cmd.done ? r_last : i_last;
    end

    // Pattern store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat[pos_now] <= i_ch;
        end
        if (rd_en) begin
            r_pat_q <= r_pat[pat_raddr];
        end
    end

    // Failure store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            r_fail[fail_waddr] <= fail_wdata;
        end
        if (rd_en) begin
            r_fail_q <= r_fail[fail_raddr];
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_ch;
            r_last <= i_last;
            r_pos  <= pos_now;
            r_j    <= r_cur_border;
        end else if (i_cmd.walk) begin
            r_j <= j_fb;
        end
    end

    // Pattern state; a word with the last flag closes the pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_pos   <= '0;
            r_cur_border <= '1;
            r_overflowed <= 1'b0;
        end else if (res_load && res_last) begin
            r_next_pos   <= '0;
            r_cur_border <= '1;
            r_overflowed <= 1'b0;
        end else if (i_cmd.load && ovf_now) begin
            r_overflowed <= 1'b1;
        end else if (i_cmd.load && pos_zero) begin
            r_cur_border <= '1;
            r_next_pos   <= POS_W'(1);
        end else if (i_cmd.done) begin
            r_cur_border <= done_border;
            r_next_pos   <= POS_W'(r_pos) + POS_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_border <= res_border[BORDER_OW-1:0];
            r_out_pos    <= res_pos_x[POS_OW-1:0];
            r_out_ovf    <= res_ovf;
            r_out_last   <= res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_DATA_W - BORDER_OW - POS_OW)'(0), r_out_pos, r_out_border};
    assign o_m_tuser  = r_out_ovf;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/kmp_failure_function_core.sv =====
// Timing: the first character of a pattern, or any character past the store size, gives
// its result in the cycle after acceptance; any other character first takes k fallback
// steps after a registered read of the pattern and failure stores, each step a further
// registered read, and then waits for room in the output register. One word at a time is
// taken; fallback steps are amortised linear in the pattern length.
// Reset (synchronous, active low) closes any open pattern and empties the output register.
`default_nettype none

module kmp_failure_function_core
    import kff_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Slave side: i_s_tdata[7:0] = ch; i_s_tlast = last.
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_s_tlast,
    // Master side: o_m_tdata[8:0] = border_end, [16:9] = position, [23:17] = zero;
    // o_m_tuser[0] = overflow; o_m_tlast = last_out.
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic                     o_m_tuser,
    output logic                     o_m_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    kff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Stores, walk and result.
    kff_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_ch       (i_s_tdata[CH_W-1:0]),
        .i_last     (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/kff_checker.sv =====
// Port-level checks of the KMP failure-table builder and their binding to the top level.
`default_nettype none

module kff_checker
    import kff_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_s_tready,
    input  wire logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [M_DATA_W-1:0] o_m_tdata,
    input  wire logic                o_m_tuser
);

    // A waiting result is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word withdrawn while stalled");

    // A new word is only taken when the output register has room for its result.
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("word accepted while output register blocked");

    // An ignored character reports no border and position zero.
    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[8:0] == 9'h1FF) && (o_m_tdata[16:9] == 8'h00))
        else $error("overflow result carries a border or position");

    // A proper border always ends before the character's own position.
    a_border_proper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            ($signed(o_m_tdata[8:0]) < $signed({1'b0, o_m_tdata[16:9]})))
        else $error("border not shorter than the prefix");

endmodule

bind kmp_failure_function_core kff_checker u_kff_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming KMP failure-table builder.
`default_nettype none

module testbench
    import kff_pkg::*;
();

    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_WORDS = 1250;
    localparam int PAD_W        = M_DATA_W - BORDER_OW - POS_OW;

    // One result word, split into its fields.
    typedef struct packed {
        logic signed [BORDER_OW-1:0] border_end;
        logic [POS_OW-1:0]           position;
        logic                        overflow;
        logic                        last_out;
    } t_kmp_result;

    // Keeps its own copy of the pattern and failure tables and predicts each result.
    class t_kmp_scoreboard;
        logic [CH_W-1:0] pattern_mem [MAX_LEN];
        int              failure_mem [MAX_LEN];
        int              next_pos;
        int              cur_border;
        bit              overflowed;
        t_kmp_result     expected_q [$];
        int              errors;

        function new();
            errors = 0;
            close_pattern();
        endfunction

        function void close_pattern();
            next_pos   = 0;
            cur_border = -1;
            overflowed = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the border for an accepted character and queues the result.
        function void note_char(logic [CH_W-1:0] c, logic l);
            t_kmp_result r;
            int          pos;
            int          j;
            int          nj;
            r.border_end = '1;
            r.position   = '0;
            r.overflow   = 1'b0;
            r.last_out   = l;
            if (overflowed || next_pos >= MAX_LEN) begin
                overflowed = 1;
                r.overflow = 1'b1;
            end else begin
                pos = next_pos;
                pattern_mem[pos] = c;
                j = -1;
                // The first character has no proper border; otherwise fall back until a match.
                if (pos != 0) begin
                    j = cur_border;
                    while (j >= 0 && j + 1 < MAX_LEN && pattern_mem[j+1] != c) begin
                        nj = failure_mem[j];
                        j  = (nj < j) ? nj : -1;
                    end
                    if (j + 1 < MAX_LEN && pattern_mem[j+1] == c)
                        j++;
                end
                failure_mem[pos] = j;
                cur_border       = j;
                next_pos         = pos + 1;
                r.border_end     = j[BORDER_OW-1:0];
                r.position       = pos[POS_OW-1:0];
            end
            expected_q = {expected_q, r};
            if (l)
                close_pattern();
        endfunction

        // Compares a result word with the oldest prediction.
        function void check_word(t_kmp_result got, logic [PAD_W-1:0] pad);
            t_kmp_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word: border_end %0d position %0d",
                         $time, got.border_end, got.position);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.border_end !== want.border_end) begin
                $display("%0t: border_end mismatch: expected %0d, got %0d",
                         $time, want.border_end, got.border_end);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position mismatch: expected %0d, got %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow mismatch: expected %0b, got %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $display("%0t: last_out mismatch: expected %0b, got %0b",
                         $time, want.last_out, got.last_out);
                errors++;
            end
            if (pad !== '0) begin
                $display("%0t: tdata padding mismatch: expected 0, got %0h", $time, pad);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;   // [7:0] ch
    logic                i_s_tlast;   // last
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // [8:0] border_end, [16:9] position, [23:17] zero
    logic                o_m_tuser;   // [0] overflow
    logic                o_m_tlast;   // last_out

    t_kmp_scoreboard sb = new();

    int s_idle_pct  = 17;
    int m_idle_pct  = 17;
    bit hold_req    = 0;
    int hold_left   = 0;
    int words_sent  = 0;
    int stall_count = 0;

    kmp_failure_function_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Monitor: note accepted characters and check accepted results.
    always @(posedge i_clk) begin
        t_kmp_result got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_char(i_s_tdata[CH_W-1:0], i_s_tlast);
            if (o_m_tvalid && i_m_tready) begin
                got.border_end = o_m_tdata[BORDER_OW-1:0];
                got.position   = o_m_tdata[BORDER_OW +: POS_OW];
                got.overflow   = o_m_tuser;
                got.last_out   = o_m_tlast;
                sb.check_word(got, o_m_tdata[M_DATA_W-1 -: PAD_W]);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("** kmp_failure_function_core: FAILED **");
            $finish;
        end
    end

    // Offers one character and returns at the rising edge that accepts it.
    task automatic send_char(input logic [CH_W-1:0] c, input logic l);
        @(negedge i_clk);
        while (s_idle_pct != 0 && $urandom_range(99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'(c);
        i_s_tlast  <= l;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        words_sent++;
    endtask

    // Lowers the valid and waits until every predicted result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // Sends a pattern over a small random alphabet, so that borders grow long.
    task automatic send_random_pattern(input int len, input int alpha_n);
        logic [CH_W-1:0] alphabet [4];
        for (int k = 0; k < 4; k++)
            alphabet[k] = CH_W'($urandom_range(255));
        for (int k = 0; k < len; k++)
            send_char(alphabet[$urandom_range(alpha_n - 1)], k == len - 1);
    endtask

    task automatic send_list(input logic [CH_W-1:0] chars [$]);
        foreach (chars[k])
            send_char(chars[k], k == chars.size() - 1);
    endtask

    // Stimulus.
    initial begin
        int pick;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-character patterns at the byte extremes, runs of one
        // character, a fallback walk, and alternating extremes.
        send_list({8'h00});
        send_list({8'hFF});
        send_list({8'hAA, 8'hAA, 8'hAA, 8'hAA});
        send_list({8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h61, 8'h62});
        send_list({8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
        send_list({8'h80, 8'h7F, 8'h80});
        drain_results();

        // A stretch with no idling on either side.
        s_idle_pct = 0;
        m_idle_pct = 0;
        while (words_sent < 180)
            send_random_pattern($urandom_range(1, 20), $urandom_range(1, 3));

        // Long receiver hold-off while the sender keeps offering characters.
        hold_req = 1;
        repeat (4)
            send_random_pattern($urandom_range(5, 15), 2);
        s_idle_pct = 17;
        m_idle_pct = 17;
        drain_results();

        // Full-length patterns: the deepest border, then an overflow that is
        // closed by a last flag on an ignored character.
        send_random_pattern(MAX_LEN, 1);
        send_random_pattern(MAX_LEN + $urandom_range(1, 6), 2);
        send_random_pattern(MAX_LEN + 1, 1);

        // Random patterns, with some noise words between them.
        while (words_sent < TARGET_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 85)
                send_random_pattern($urandom_range(1, (pick < 10) ? 60 : 24),
                                    $urandom_range(1, 4));
            else
                send_char(CH_W'($urandom_range(255)), $urandom_range(3) == 0);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** kmp_failure_function_core: PASSED **");
        else
            $display("** kmp_failure_function_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/kff_pkg.sv
rtl/kff_ctrl.sv
rtl/kff_datapath.sv
rtl/kmp_failure_function_core.sv
rtl/kff_checker.sv
dv/testbench.sv
